FILE: rtl/nsc_pkg.sv
// Package for the NMEA sentence checker: character codes, result encodings,
// the result struct and small helper functions. Depends on nothing else.
package nsc_pkg;

    localparam int unsigned COUNT_W = 7;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned HDR_N   = 5;

    localparam logic [BYTE_W-1:0] CTRL_LIMIT = 8'd21;
    localparam logic [BYTE_W-1:0] CH_LF      = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR      = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_DOLLAR  = 8'h24;
    localparam logic [BYTE_W-1:0] CH_STAR    = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_A       = 8'h41;
    localparam logic [BYTE_W-1:0] CH_C       = 8'h43;
    localparam logic [BYTE_W-1:0] CH_G       = 8'h47;
    localparam logic [BYTE_W-1:0] CH_L       = 8'h4C;
    localparam logic [BYTE_W-1:0] CH_M       = 8'h4D;
    localparam logic [BYTE_W-1:0] CH_N       = 8'h4E;
    localparam logic [BYTE_W-1:0] CH_P       = 8'h50;
    localparam logic [BYTE_W-1:0] CH_R       = 8'h52;

    localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CH_HEX_OFS = 8'h37;   // 'A' minus ten
    localparam logic [3:0]        NIB_TEN    = 4'd10;

    localparam logic [1:0] DIG_NONE = 2'd0;
    localparam logic [1:0] DIG_ONE  = 2'd1;
    localparam logic [1:0] DIG_TWO  = 2'd2;

    localparam logic [1:0] ST_GOOD = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_DROP = 2'd2;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_RMC  = 2'd1;
    localparam logic [1:0] KIND_GGA  = 2'd2;

    localparam int unsigned RES_W = 13;
    localparam int unsigned RES_BYTES_W = 16;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef byte_t [HDR_N-1:0] header_t;

    typedef struct packed {
        logic [BYTE_W-1:0] computed_checksum;
        logic              standby_request;
        logic [1:0]        sentence_kind;
        logic [1:0]        status;
    } result_t;

    function automatic byte_t hex_char(input logic [3:0] nib);
        if (nib < NIB_TEN)
        begin
            return CH_ZERO + {4'h0, nib};
        end
        return CH_HEX_OFS + {4'h0, nib};
    endfunction

    function automatic logic [1:0] classify(input header_t hdr);
        logic talker_ok;
        talker_ok = (hdr[0] == CH_G) &&
                    (hdr[1] == CH_P || hdr[1] == CH_L || hdr[1] == CH_N);
        if (talker_ok && hdr[2] == CH_R && hdr[3] == CH_M && hdr[4] == CH_C)
        begin
            return KIND_RMC;
        end
        if (talker_ok && hdr[2] == CH_G && hdr[3] == CH_G && hdr[4] == CH_A)
        begin
            return KIND_GGA;
        end
        return KIND_NONE;
    endfunction

endpackage

FILE: rtl/nsc_sentence.sv
// Sentence state and per-byte decode for the NMEA sentence checker.
// Uses nsc_pkg for character codes, the result struct and helpers.
module nsc_sentence #(
    parameter int unsigned MAX_LEN = 100
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  logic [nsc_pkg::BYTE_W-1:0] rx_byte,
    output logic                    has_result,
    output nsc_pkg::result_t        result
);

    localparam logic [nsc_pkg::COUNT_W-1:0] LIMIT = nsc_pkg::COUNT_W'(MAX_LEN - 2);
    localparam logic [nsc_pkg::COUNT_W-1:0] MIN_COUNT = nsc_pkg::COUNT_W'(3);

    logic [nsc_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [nsc_pkg::BYTE_W-1:0]  xor_reg, xor_next;
    logic                        star_reg, star_next;
    logic [1:0]                  digits_reg, digits_next;
    logic [nsc_pkg::BYTE_W-1:0]  first_reg, first_next;
    logic [nsc_pkg::BYTE_W-1:0]  second_reg, second_next;
    nsc_pkg::header_t            hdr_reg, hdr_next;
    logic                        standby_reg, standby_next;

    logic [nsc_pkg::COUNT_W-1:0] pos;
    logic                        ignored;
    logic                        good;

    // The decode looks only at the held byte and the state, so has_result is
    // known before step is; the state registers advance only on step.
    always_comb
    begin
        count_next   = count_reg;
        xor_next     = xor_reg;
        star_next    = star_reg;
        digits_next  = digits_reg;
        first_next   = first_reg;
        second_next  = second_reg;
        hdr_next     = hdr_reg;
        standby_next = standby_reg;
        has_result   = 1'b0;
        result       = '0;
        pos          = count_reg;
        good         = 1'b0;
        ignored      = (rx_byte < nsc_pkg::CTRL_LIMIT) &&
                       (rx_byte != nsc_pkg::CH_LF) && (rx_byte != nsc_pkg::CH_CR);

        if (count_reg >= LIMIT)
        begin
            // Sentence too long: drop it and report the checksum so far.
            has_result               = 1'b1;
            result.status            = nsc_pkg::ST_DROP;
            result.computed_checksum = xor_reg;
            count_next  = '0;
            xor_next    = '0;
            star_next   = 1'b0;
            digits_next = nsc_pkg::DIG_NONE;
            first_next  = '0;
            second_next = '0;
            hdr_next    = '0;
        end
        else if (!ignored)
        begin
            if (rx_byte == nsc_pkg::CH_DOLLAR)
            begin
                count_next  = '0;
                xor_next    = '0;
                star_next   = 1'b0;
                digits_next = nsc_pkg::DIG_NONE;
                first_next  = '0;
                second_next = '0;
                hdr_next    = '0;
            end
            pos        = count_next;
            count_next = pos + 1'b1;

            for (int i = 0; i < nsc_pkg::HDR_N; i++)
            begin
                if (pos == nsc_pkg::COUNT_W'(i + 1))
                begin
                    hdr_next[i] = rx_byte;
                end
            end

            if (pos != '0)
            begin
                if (!star_next)
                begin
                    if (rx_byte == nsc_pkg::CH_STAR)
                    begin
                        star_next = 1'b1;
                    end
                    else
                    begin
                        xor_next = xor_next ^ rx_byte;
                    end
                end
                else if (digits_next == nsc_pkg::DIG_NONE)
                begin
                    first_next  = rx_byte;
                    digits_next = nsc_pkg::DIG_ONE;
                end
                else if (digits_next == nsc_pkg::DIG_ONE)
                begin
                    second_next = rx_byte;
                    digits_next = nsc_pkg::DIG_TWO;
                end
            end

            if (rx_byte == nsc_pkg::CH_LF && count_next > MIN_COUNT)
            begin
                good = star_next && digits_next == nsc_pkg::DIG_TWO &&
                       first_next == nsc_pkg::hex_char(xor_next[7:4]) &&
                       second_next == nsc_pkg::hex_char(xor_next[3:0]);
                has_result               = 1'b1;
                result.computed_checksum = xor_next;
                if (good)
                begin
                    result.status          = nsc_pkg::ST_GOOD;
                    result.sentence_kind   = nsc_pkg::classify(hdr_next);
                    result.standby_request = standby_reg;
                    standby_next           = 1'b0;
                end
                else
                begin
                    result.status = nsc_pkg::ST_BAD;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            xor_reg     <= '0;
            star_reg    <= 1'b0;
            digits_reg  <= nsc_pkg::DIG_NONE;
            first_reg   <= '0;
            second_reg  <= '0;
            hdr_reg     <= '0;
            standby_reg <= 1'b1;
        end
        else if (step)
        begin
            count_reg   <= count_next;
            xor_reg     <= xor_next;
            star_reg    <= star_next;
            digits_reg  <= digits_next;
            first_reg   <= first_next;
            second_reg  <= second_next;
            hdr_reg     <= hdr_next;
            standby_reg <= standby_next;
        end
    end

endmodule

FILE: rtl/nmea_sentence_checker.sv
// NMEA 0183 sentence checker, one received byte per input beat. Each beat
// passes through an input register, is decoded against the sentence state and,
// when it ends a sentence or overflows it, leaves a result in the output
// register. Throughput is one byte per clock unless a held result beat stalls
// it; the single state update per byte in nsc_sentence sets that rate. Output
// beats carry status (0 good, 1 bad or missing checksum, 2 dropped for length),
// the RMC/GGA class, the standby flag and the computed XOR. MAX_LEN bounds the
// sentence at MAX_LEN-2 bytes. Depends on nsc_pkg and nsc_sentence.
module nmea_sentence_checker #(
    parameter int unsigned MAX_LEN = 100
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [1:0] status, [3:2] sentence_kind,
                                   // [4] standby_request, [12:5] computed_checksum
);

    logic                       in_valid_reg;
    logic [nsc_pkg::BYTE_W-1:0] in_byte_reg;
    logic                       out_valid_reg;
    nsc_pkg::result_t           out_reg;

    logic             step;
    logic             has_result;
    nsc_pkg::result_t result;
    logic             out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && (out_free || !has_result);
    assign s_tready = !in_valid_reg || step;

    nsc_sentence #(
        .MAX_LEN(MAX_LEN)
    ) u_sentence (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .rx_byte   (in_byte_reg),
        .has_result(has_result),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (step && has_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
        end
        if (step && has_result)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(nsc_pkg::RES_BYTES_W - nsc_pkg::RES_W)'(0), out_reg};

endmodule
